FILE: hw/rtl/dpp_pkg.sv
package dpp_pkg;

  // field widths
  localparam int DEPTH_W      = 16;
  localparam int PIX_W        = 12;
  localparam int COLOR_W      = 8;
  localparam int DIM_REG_W    = 13;
  localparam int DEPTH_UNIT_W = 25;
  localparam int SCALE_W      = 32;
  localparam int CENTER_W     = 29;
  localparam int Z_W          = 32;
  localparam int COORD_W      = 48;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH       = 3'd0,
    REG_IMAGE_HEIGHT      = 3'd1,
    REG_DEPTH_UNIT        = 3'd2,
    REG_MANUAL_INTRINSICS = 3'd3,
    REG_INV_FOCAL_X       = 3'd4,
    REG_INV_FOCAL_Y       = 3'd5,
    REG_PRINCIPAL_X       = 3'd6,
    REG_PRINCIPAL_Y       = 3'd7
  } cfg_reg_t;

  // register reset values
  localparam logic [DIM_REG_W-1:0]    IMAGE_WIDTH_RST  = 13'd640;
  localparam logic [DIM_REG_W-1:0]    IMAGE_HEIGHT_RST = 13'd480;
  localparam logic [DEPTH_UNIT_W-1:0] DEPTH_UNIT_RST   = 25'd16777;
  localparam logic [SCALE_W-1:0]      INV_FOCAL_RST    = 32'd8180890;
  localparam logic [CENTER_W-1:0]     PRINCIPAL_X_RST  = 29'd20938752;
  localparam logic [CENTER_W-1:0]     PRINCIPAL_Y_RST  = 29'd15695872;

  // automatic scale is 640 * 2^32 / (525 * width)
  localparam int              DIV_NUM_W = 42;
  localparam int              DIV_CNT_W = $clog2(DIV_NUM_W);
  localparam logic [DIV_NUM_W-1:0] DIV_NUM = 42'd640 << 32;
  localparam int              SCALE_MUL = 525;
  // automatic center is (size - 1) in Q16.16 halved, kept to the low bits
  localparam int              CENTER_HALF_SHIFT = 15;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth_raw;
    logic [PIX_W-1:0]   pixel_col;
    logic [PIX_W-1:0]   pixel_row;
    logic [COLOR_W-1:0] red_in;
    logic [COLOR_W-1:0] green_in;
    logic [COLOR_W-1:0] blue_in;
  } pixel_beat_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [Z_W-1:0]            point_z;
    logic                      point_valid;
    logic [COLOR_W-1:0]        red_out;
    logic [COLOR_W-1:0]        green_out;
    logic [COLOR_W-1:0]        blue_out;
  } point_beat_t;

  typedef struct packed {
    logic [SCALE_W-1:0]  scale_x;
    logic [SCALE_W-1:0]  scale_y;
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
  } intrinsics_t;

endpackage

FILE: hw/rtl/dpp_stream_if.sv
interface dpp_stream_if #(parameter type beat_t = logic);
  logic  valid;
  logic  ready;
  beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/dpp_pipe.sv
module dpp_pipe (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             hold,
  input  logic [dpp_pkg::DEPTH_UNIT_W-1:0] depth_unit,
  input  dpp_pkg::intrinsics_t             intr,
  dpp_stream_if.sink                       pixel_in,
  dpp_stream_if.source                     point_out
);
  import dpp_pkg::*;

  localparam int NUM_STAGES = 6;
  localparam int PROD_W = DEPTH_W + DEPTH_UNIT_W;
  localparam int MAG_W  = CENTER_W;
  localparam int DIFF_W = MAG_W + 1;
  localparam int T_W    = MAG_W + SCALE_W;
  localparam int TH_W   = T_W - 32;
  localparam int LO_W   = 32 + Z_W;
  localparam int HZ_W   = TH_W + Z_W;
  localparam int HI_W   = HZ_W + 1;
  localparam int R_W    = HI_W - 16;
  localparam int RGB_W  = 3 * COLOR_W;

  // sign and magnitude of (pixel in Q16.16) minus center
  function automatic logic [DIFF_W-1:0] offset_mag(input logic [PIX_W-1:0] pix,
                                                   input logic [CENTER_W-1:0] center);
    logic [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0] neg_diff;
    diff     = DIFF_W'({pix, 16'd0}) - DIFF_W'(center);
    neg_diff = -diff;
    if (diff[DIFF_W-1]) begin
      return {1'b1, neg_diff[MAG_W-1:0]};
    end
    return {1'b0, diff[MAG_W-1:0]};
  endfunction

  logic [NUM_STAGES:1]   vld;
  logic [NUM_STAGES+1:1] en;
  logic                  accept;
  logic [DIFF_W-1:0]     offs_x;
  logic [DIFF_W-1:0]     offs_y;
  logic [PROD_W-1:0]     z_sum;
  logic [HI_W-1:0]       r_sum_x;
  logic [HI_W-1:0]       r_sum_y;

  // stage 1: depth product, offsets from center
  logic [PROD_W-1:0] s1_prod;
  logic              s1_negx, s1_negy;
  logic [MAG_W-1:0]  s1_magx, s1_magy;
  logic [RGB_W-1:0]  s1_rgb;
  // stage 2: z, offset times scale
  logic [Z_W-1:0]    s2_z;
  logic              s2_nz, s2_negx, s2_negy;
  logic [T_W-1:0]    s2_tx, s2_ty;
  logic [RGB_W-1:0]  s2_rgb;
  // stage 3: partial products with z
  logic [Z_W-1:0]    s3_z;
  logic              s3_nz, s3_negx, s3_negy;
  logic [LO_W-1:0]   s3_lox, s3_loy;
  logic [HZ_W-1:0]   s3_hix, s3_hiy;
  logic [RGB_W-1:0]  s3_rgb;
  // stage 4: partial products joined
  logic [Z_W-1:0]    s4_z;
  logic              s4_nz, s4_negx, s4_negy;
  logic [HI_W-1:0]   s4_hx, s4_hy;
  logic [RGB_W-1:0]  s4_rgb;
  // stage 5: rounded magnitude
  logic [Z_W-1:0]    s5_z;
  logic              s5_nz, s5_negx, s5_negy;
  logic [R_W-1:0]    s5_rx, s5_ry;
  logic [RGB_W-1:0]  s5_rgb;
  // stage 6: output register
  point_beat_t       s6_beat;

  // per-stage advance: a stage loads when empty or when its successor moves
  always_comb begin
    en[NUM_STAGES+1] = point_out.ready;
    for (int k = NUM_STAGES; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign pixel_in.ready  = en[1] && !hold;
  assign accept          = pixel_in.valid && pixel_in.ready;
  assign point_out.valid = vld[NUM_STAGES];
  assign point_out.data  = s6_beat;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= accept;
      end
      for (int k = 2; k <= NUM_STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign offs_x = offset_mag(pixel_in.data.pixel_col, intr.center_x);
  assign offs_y = offset_mag(pixel_in.data.pixel_row, intr.center_y);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_prod <= PROD_W'(pixel_in.data.depth_raw) * PROD_W'(depth_unit);
      s1_negx <= offs_x[DIFF_W-1];
      s1_magx <= offs_x[MAG_W-1:0];
      s1_negy <= offs_y[DIFF_W-1];
      s1_magy <= offs_y[MAG_W-1:0];
      s1_rgb  <= {pixel_in.data.red_in, pixel_in.data.green_in, pixel_in.data.blue_in};
    end
  end

  // z rounded half up from Q.24 to Q16.16
  assign z_sum = s1_prod + PROD_W'(128);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_z    <= z_sum[Z_W+7:8];
      s2_nz   <= (s1_prod != '0);
      s2_negx <= s1_negx;
      s2_negy <= s1_negy;
      s2_tx   <= T_W'(s1_magx) * T_W'(intr.scale_x);
      s2_ty   <= T_W'(s1_magy) * T_W'(intr.scale_y);
      s2_rgb  <= s1_rgb;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_z    <= s2_z;
      s3_nz   <= s2_nz;
      s3_negx <= s2_negx;
      s3_negy <= s2_negy;
      s3_lox  <= LO_W'(s2_tx[31:0]) * LO_W'(s2_z);
      s3_loy  <= LO_W'(s2_ty[31:0]) * LO_W'(s2_z);
      s3_hix  <= HZ_W'(s2_tx[T_W-1:32]) * HZ_W'(s2_z);
      s3_hiy  <= HZ_W'(s2_ty[T_W-1:32]) * HZ_W'(s2_z);
      s3_rgb  <= s2_rgb;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_z    <= s3_z;
      s4_nz   <= s3_nz;
      s4_negx <= s3_negx;
      s4_negy <= s3_negy;
      s4_hx   <= HI_W'(s3_hix) + HI_W'(s3_lox[LO_W-1:32]);
      s4_hy   <= HI_W'(s3_hiy) + HI_W'(s3_loy[LO_W-1:32]);
      s4_rgb  <= s3_rgb;
    end
  end

  // round half up to Q16.16, the low product bits only shift the half point
  assign r_sum_x = s4_hx + HI_W'(32768);
  assign r_sum_y = s4_hy + HI_W'(32768);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_z    <= s4_z;
      s5_nz   <= s4_nz;
      s5_negx <= s4_negx;
      s5_negy <= s4_negy;
      s5_rx   <= r_sum_x[HI_W-1:16];
      s5_ry   <= r_sum_y[HI_W-1:16];
      s5_rgb  <= s4_rgb;
    end
  end

  // sign applied; the magnitude stays below 2^46 so no clamp is needed,
  // and a zero depth already gives zero x, y and z
  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_beat.point_x     <= s5_negx ? -COORD_W'(s5_rx) : COORD_W'(s5_rx);
      s6_beat.point_y     <= s5_negy ? -COORD_W'(s5_ry) : COORD_W'(s5_ry);
      s6_beat.point_z     <= s5_z;
      s6_beat.point_valid <= s5_nz;
      s6_beat.red_out     <= s5_rgb[RGB_W-1 -: COLOR_W];
      s6_beat.green_out   <= s5_rgb[2*COLOR_W-1 -: COLOR_W];
      s6_beat.blue_out    <= s5_rgb[COLOR_W-1:0];
    end
  end

  // accepted beat lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    accept |=> vld[1])
    else $error("accepted beat missing from stage 1");

  // a stalled result is not dropped
  a_stall_keeps: assert property (@(posedge clk) disable iff (rst)
    vld[NUM_STAGES] && !point_out.ready |=> vld[NUM_STAGES])
    else $error("stalled result lost");

  // an invalid point carries zero coordinates
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    point_out.valid && !s6_beat.point_valid |->
      s6_beat.point_x == '0 && s6_beat.point_y == '0 && s6_beat.point_z == '0)
    else $error("invalid point with nonzero coordinates");

  // a nonzero depth only comes from a valid point
  a_z_valid: assert property (@(posedge clk) disable iff (rst)
    point_out.valid && s6_beat.point_z != '0 |-> s6_beat.point_valid)
    else $error("nonzero depth on invalid point");

endmodule

FILE: hw/rtl/depth_pixel_to_point.sv
// channel    | dir | beat type     | handshake
// -----------+-----+---------------+--------------------------------
// pixel_in   | in  | pixel_beat_t  | valid/ready, beat on both high
// point_out  | out | point_beat_t  | valid/ready, beat on both high
// cfg_*      | in  | register data | write on cfg_write, no wait
//
// one beat per cycle through a six-stage pipeline unless point_out stalls or the divider holds pixel_in
// reset clears the pipeline; beats are taken in the first cycle after reset
// a write to image_width starts the bit-serial scale divider: pixel_in is
// held off while it runs, one quotient bit per cycle
// a stall on point_out backs up stage by stage; empty stages still fill
module depth_pixel_to_point #(
  parameter int MAX_DIM = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [dpp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dpp_pkg::CFG_DATA_W-1:0]  cfg_data,
  dpp_stream_if.sink                     pixel_in,
  dpp_stream_if.source                   point_out
);
  import dpp_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int DIV_W = $clog2(SCALE_MUL * MAX_DIM + 1);
  localparam int RESET_DIM = (640 > MAX_DIM) ? MAX_DIM : 640;
  localparam longint unsigned RESET_Q = DIV_NUM / (SCALE_MUL * RESET_DIM);
  localparam logic [SCALE_W-1:0] RESET_SCALE =
    ((RESET_Q >> SCALE_W) != 0) ? {SCALE_W{1'b1}} : SCALE_W'(RESET_Q);

  // size used for automatic intrinsics: zero as one, clamped to MAX_DIM
  function automatic logic [DIM_W-1:0] dim_eff(input logic [DIM_REG_W-1:0] d);
    logic [31:0] d32;
    d32 = 32'(d);
    if (d32 == 32'd0) begin
      return DIM_W'(1);
    end else if (d32 > MAX_DIM) begin
      return DIM_W'(MAX_DIM);
    end
    return DIM_W'(d32);
  endfunction

  logic [DIM_REG_W-1:0]    image_width;
  logic [DIM_REG_W-1:0]    image_height;
  logic [DEPTH_UNIT_W-1:0] depth_unit;
  logic                    manual_intrinsics;
  logic [SCALE_W-1:0]      inv_focal_x;
  logic [SCALE_W-1:0]      inv_focal_y;
  logic [CENTER_W-1:0]     principal_x;
  logic [CENTER_W-1:0]     principal_y;

  logic                    width_write;
  logic                    div_busy;
  logic [DIV_CNT_W-1:0]    div_cnt;
  logic [DIV_W-1:0]        div_den;
  logic [DIV_W-1:0]        div_rem;
  logic [DIV_NUM_W-1:0]    div_quo;
  logic [DIV_W:0]          rem_shift;
  logic [DIV_W:0]          rem_diff;
  logic                    rem_ge;
  logic [DIV_NUM_W-1:0]    quo_next;
  logic [SCALE_W-1:0]      auto_scale;

  logic [31:0]             width_m1;
  logic [31:0]             height_m1;
  intrinsics_t             intr;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width       <= IMAGE_WIDTH_RST;
      image_height      <= IMAGE_HEIGHT_RST;
      depth_unit        <= DEPTH_UNIT_RST;
      manual_intrinsics <= 1'b0;
      inv_focal_x       <= INV_FOCAL_RST;
      inv_focal_y       <= INV_FOCAL_RST;
      principal_x       <= PRINCIPAL_X_RST;
      principal_y       <= PRINCIPAL_Y_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:       image_width       <= cfg_data[DIM_REG_W-1:0];
        REG_IMAGE_HEIGHT:      image_height      <= cfg_data[DIM_REG_W-1:0];
        REG_DEPTH_UNIT:        depth_unit        <= cfg_data[DEPTH_UNIT_W-1:0];
        REG_MANUAL_INTRINSICS: manual_intrinsics <= cfg_data[0];
        REG_INV_FOCAL_X:       inv_focal_x       <= cfg_data[SCALE_W-1:0];
        REG_INV_FOCAL_Y:       inv_focal_y       <= cfg_data[SCALE_W-1:0];
        REG_PRINCIPAL_X:       principal_x       <= cfg_data[CENTER_W-1:0];
        REG_PRINCIPAL_Y:       principal_y       <= cfg_data[CENTER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign width_write = cfg_write && (cfg_index == REG_IMAGE_WIDTH);

  // restoring divider step: one quotient bit per cycle
  always_comb begin
    rem_shift = {div_rem, DIV_NUM[div_cnt]};
    rem_diff  = rem_shift - {1'b0, div_den};
    rem_ge    = (rem_shift >= {1'b0, div_den});
    quo_next  = {div_quo[DIV_NUM_W-2:0], rem_ge};
  end

  // divider control and result
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy   <= 1'b0;
      div_cnt    <= '0;
      auto_scale <= RESET_SCALE;
    end else if (width_write) begin
      div_busy <= 1'b1;
      div_cnt  <= DIV_CNT_W'(DIV_NUM_W - 1);
    end else if (div_busy) begin
      if (div_cnt == '0) begin
        div_busy   <= 1'b0;
        auto_scale <= (quo_next[DIV_NUM_W-1:SCALE_W] != '0) ? {SCALE_W{1'b1}}
                                                            : quo_next[SCALE_W-1:0];
      end else begin
        div_cnt <= div_cnt - DIV_CNT_W'(1);
      end
    end
  end

  // divider datapath
  always_ff @(posedge clk) begin
    if (width_write) begin
      div_den <= DIV_W'(SCALE_MUL) * DIV_W'(dim_eff(cfg_data[DIM_REG_W-1:0]));
      div_rem <= '0;
      div_quo <= '0;
    end else if (div_busy) begin
      div_rem <= rem_ge ? rem_diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
      div_quo <= quo_next;
    end
  end

  // intrinsics in use
  always_comb begin
    width_m1  = 32'(dim_eff(image_width)) - 32'd1;
    height_m1 = 32'(dim_eff(image_height)) - 32'd1;
    if (manual_intrinsics) begin
      intr.scale_x  = inv_focal_x;
      intr.scale_y  = inv_focal_y;
      intr.center_x = principal_x;
      intr.center_y = principal_y;
    end else begin
      intr.scale_x  = auto_scale;
      intr.scale_y  = auto_scale;
      intr.center_x = {width_m1[CENTER_W-CENTER_HALF_SHIFT-1:0], {CENTER_HALF_SHIFT{1'b0}}};
      intr.center_y = {height_m1[CENTER_W-CENTER_HALF_SHIFT-1:0], {CENTER_HALF_SHIFT{1'b0}}};
    end
  end

  dpp_pipe u_pipe (
    .clk        (clk),
    .rst        (rst),
    .hold       (div_busy),
    .depth_unit (depth_unit),
    .intr       (intr),
    .pixel_in   (pixel_in),
    .point_out  (point_out)
  );

  // a width write always starts the divider
  a_width_starts_div: assert property (@(posedge clk) disable iff (rst)
    width_write |=> div_busy)
    else $error("width write did not start divider");

  // no pixel is taken while the scale is being recomputed
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> !pixel_in.ready)
    else $error("pixel accepted during scale update");

  // the divider finishes after its last bit
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_busy && div_cnt == '0 && !width_write |=> !div_busy)
    else $error("divider did not finish");

endmodule
